// ===== hw/rtl/amm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_pkg
// Shared types and constants for the constant-product swap and profit unit.
// ----------------------------------------------------------------------------
package amm_pkg;

    localparam int unsigned WORD_W   = 128;
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned LIMB_W   = 32;
    localparam int unsigned LIMBS    = WORD_W / LIMB_W;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned IN_DATA_W = 10 * HALF_W;

    localparam logic [WORD_W-1:0] FEE_NUM = WORD_W'(997);
    localparam logic [WORD_W-1:0] FEE_DEN = WORD_W'(1000);

    localparam logic MODE_SWAP   = 1'b0;
    localparam logic MODE_PROFIT = 1'b1;

    typedef logic [WORD_W-1:0] t_u128;

    typedef struct packed {
        logic  func;
        t_u128 res_a;
        t_u128 res_b;
        t_u128 res_c;
        t_u128 res_d;
        t_u128 amount;
    } t_req;

    typedef struct packed {
        logic  func;
        t_u128 amount;
        t_u128 res_c;
        t_u128 res_d;
    } t_side;

    typedef struct packed {
        logic vld;
        logic full;
    } t_front_stat;

endpackage

// ===== hw/rtl/amm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_front
// Accepts items, unpacks operand fields and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module amm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [amm_pkg::IN_DATA_W-1:0]   s_tdata,  // a_lo,a_hi,b_lo,b_hi,c_lo,c_hi,d_lo,d_hi,amount_lo,amount_hi
    input  logic                            s_tuser,  // func
    input  logic                            i_take,
    output amm_pkg::t_req                   o_req,
    output amm_pkg::t_front_stat            o_stat
);
    import amm_pkg::*;

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_in;
    logic       w_push, w_pop;

    always_comb begin
        w_in.func   = s_tuser;
        w_in.res_a  = s_tdata[2*HALF_W-1:0];
        w_in.res_b  = s_tdata[4*HALF_W-1:2*HALF_W];
        w_in.res_c  = s_tdata[6*HALF_W-1:4*HALF_W];
        w_in.res_d  = s_tdata[8*HALF_W-1:6*HALF_W];
        w_in.amount = s_tdata[10*HALF_W-1:8*HALF_W];
    end

    assign s_tready    = (r_cnt != 2'd2);
    assign w_push      = s_tvalid && s_tready;
    assign w_pop       = i_take && (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];
    assign o_stat.vld  = (r_cnt != 2'd0);
    assign o_stat.full = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

// ===== hw/rtl/amm_swap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_swap
// Pipelined swap quote: fee, wrapped products, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module amm_swap (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  amm_pkg::t_u128      i_rin,
    input  amm_pkg::t_u128      i_rout,
    input  amm_pkg::t_u128      i_amt,
    input  amm_pkg::t_side      i_side,
    output logic                o_vld,
    output amm_pkg::t_u128      o_q,
    output amm_pkg::t_side      o_side
);
    import amm_pkg::*;

    logic  r0_vld, r0_zero;
    t_u128 r0_fee, r0_rin, r0_rout;
    t_side r0_side;

    logic        r1_vld, r1_zero;
    logic [2*LIMB_W-1:0] r1_pp [LIMBS][LIMBS];
    t_u128       r1_den;
    t_side       r1_side;

    logic  r_vld  [DIV_STEPS+1];
    logic  r_zero [DIV_STEPS+1];
    t_u128 r_rem  [DIV_STEPS+1];
    t_u128 r_num  [DIV_STEPS+1];
    t_u128 r_quo  [DIV_STEPS+1];
    t_u128 r_den  [DIV_STEPS+1];
    t_side r_side [DIV_STEPS+1];

    t_u128 w_num;

    always_comb begin
        w_num = '0;
        for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
                w_num = w_num + (WORD_W'(r1_pp[i][j]) << (LIMB_W * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_fee  <= i_amt * FEE_NUM;
            r0_rin  <= i_rin * FEE_DEN;
            r0_rout <= i_rout;
            r0_zero <= (i_rin == '0) || (i_amt == '0);
            r0_side <= i_side;

            for (int i = 0; i < LIMBS; i++) begin
                for (int j = 0; j < LIMBS; j++) begin
                    if (i + j < LIMBS) begin
                        r1_pp[i][j] <= r0_rout[i*LIMB_W +: LIMB_W] * r0_fee[j*LIMB_W +: LIMB_W];
                    end else begin
                        r1_pp[i][j] <= '0;
                    end
                end
            end
            r1_den  <= r0_rin + r0_fee;
            r1_zero <= r0_zero;
            r1_side <= r0_side;

            r_rem[0]  <= '0;
            r_num[0]  <= w_num;
            r_quo[0]  <= '0;
            r_den[0]  <= r1_den;
            r_zero[0] <= r1_zero || (r1_den == '0);
            r_side[0] <= r1_side;
        end
        if (!i_rst_n) begin
            r0_vld   <= 1'b0;
            r1_vld   <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r0_vld   <= i_vld;
            r1_vld   <= r0_vld;
            r_vld[0] <= r1_vld;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [WORD_W:0] w_sh;
        logic [WORD_W:0] w_diff;
        logic            w_ge;

        assign w_sh   = {r_rem[k], r_num[k][WORD_W-1]};
        assign w_diff = w_sh - {1'b0, r_den[k]};
        assign w_ge   = (w_sh >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? w_diff[WORD_W-1:0] : w_sh[WORD_W-1:0];
                r_num[k+1]  <= r_num[k] << 1;
                r_quo[k+1]  <= {r_quo[k][WORD_W-2:0], w_ge};
                r_den[k+1]  <= r_den[k];
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS];
    assign o_q    = r_zero[DIV_STEPS] ? '0 : r_quo[DIV_STEPS];
    assign o_side = r_side[DIV_STEPS];

endmodule

// ===== hw/rtl/amm_swap_output_and_round_trip_profit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_swap_output_and_round_trip_profit_unit
// Constant-product swap output and two-pool round-trip profit quote.
//
// Channel | Dir | tdata                                   | tuser
// s_axis  | in  | reserves a..d, amount (lo/hi, 640 bits) | func
// m_axis  | out | result_lo, result_hi (128 bits)         | -
//
// One item per cycle sustained while the output is not stalled. From acceptance:
// queue read in the same cycle as the first product stage, two 131-stage swap
// pipelines (3 product stages, 128 quotient stages), output register.
// Synchronous active-low reset clears valids, queue pointers and fill count only. A stalled
// output freezes both pipelines; the queue keeps accepting until its two entries are full.
// ----------------------------------------------------------------------------
module amm_swap_output_and_round_trip_profit_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [amm_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // a_lo,a_hi,b_lo,b_hi,c_lo,c_hi,d_lo,d_hi,amount_lo,amount_hi
    input  logic                           s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [amm_pkg::WORD_W-1:0]     m_axis_tdata   // result_lo, result_hi
);
    import amm_pkg::*;

    t_req        w_req;
    t_front_stat w_fstat;
    logic        w_en, w_take;
    t_side       w_side0, w_side1, w_side2;
    logic        w_v1, w_v2;
    t_u128       w_mid, w_back, w_res;
    logic        r_ovld;
    t_u128       r_odata;

    assign w_en   = !r_ovld || m_axis_tready;
    assign w_take = w_en && w_fstat.vld;

    amm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .i_take   (w_take),
        .o_req    (w_req),
        .o_stat   (w_fstat)
    );

    always_comb begin
        w_side0.func   = w_req.func;
        w_side0.amount = w_req.amount;
        w_side0.res_c  = w_req.res_c;
        w_side0.res_d  = w_req.res_d;
    end

    amm_swap u_buy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_take),
        .i_rin   (w_req.res_a),
        .i_rout  (w_req.res_b),
        .i_amt   (w_req.amount),
        .i_side  (w_side0),
        .o_vld   (w_v1),
        .o_q     (w_mid),
        .o_side  (w_side1)
    );

    t_side w_side1b;
    always_comb begin
        w_side1b        = w_side1;
        w_side1b.res_c  = w_mid;
    end

    amm_swap u_sell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_v1),
        .i_rin   (w_side1.res_d),
        .i_rout  (w_side1.res_c),
        .i_amt   (w_mid),
        .i_side  (w_side1b),
        .o_vld   (w_v2),
        .o_q     (w_back),
        .o_side  (w_side2)
    );

    always_comb begin
        if (w_side2.func == MODE_SWAP) begin
            w_res = w_side2.res_c;
        end else if (w_back > w_side2.amount) begin
            w_res = w_back - w_side2.amount;
        end else begin
            w_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= w_res;
        end
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_v2;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(w_v2))
        else $error("output valid without pipeline result");
    a_take_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |-> !w_take)
        else $error("queue read while output stalled");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == !w_fstat.full)
        else $error("input ready disagrees with queue fill");
`endif

endmodule

// ===== bench/amm_swap_output_and_round_trip_profit_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm_swap_output_and_round_trip_profit_unit_tb
// Streams swap and round-trip profit quotes through the unit, predicts each
// result with 128-bit wrapping arithmetic and checks the output in order,
// under random gaps on both sides and long output holds.
// ----------------------------------------------------------------------------
module amm_swap_output_and_round_trip_profit_unit_tb;

    import amm_pkg::*;

    typedef struct packed {
        logic  func;
        t_u128 a;
        t_u128 b;
        t_u128 c;
        t_u128 d;
        t_u128 amt;
    } t_quote;

    localparam int LATENCY = 263;
    localparam longint LIMIT = 3000000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [WORD_W-1:0]     m_axis_tdata;

    t_quote pending_q[$];
    t_u128  quote_q[$];
    int     n_err;
    longint cyc;
    int     src_gap;
    int     sink_gap;
    int     sink_hold;
    bit     drain_req;

    amm_swap_output_and_round_trip_profit_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_u128 swap_amount(t_u128 r_in, t_u128 r_out, t_u128 amt);
        t_u128 fee;
        t_u128 num;
        t_u128 den;
        if (r_in == '0 || amt == '0) begin
            return '0;
        end
        fee = amt * FEE_NUM;
        num = r_out * fee;
        den = r_in * FEE_DEN + fee;
        if (den == '0) begin
            return '0;
        end
        return num / den;
    endfunction

    function automatic t_u128 quote_result(t_quote q);
        t_u128 mid;
        t_u128 back;
        mid = swap_amount(q.a, q.b, q.amt);
        if (q.func == MODE_SWAP) begin
            return mid;
        end
        back = swap_amount(q.d, q.c, mid);
        return (back > q.amt) ? back - q.amt : '0;
    endfunction

    function automatic t_u128 rand_u128(int kind);
        t_u128 v;
        v = {$urandom, $urandom, $urandom, $urandom};
        case (kind)
            0: v = '0;
            1: v = '1;
            2: v = t_u128'($urandom_range(1, 20));
            3: v = v >> $urandom_range(0, 127);
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_u128 rand_field();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return rand_field_edge($urandom_range(0, 2));
        if (r < 40) return rand_u128(4);
        return rand_u128(3);
    endfunction

    function automatic t_u128 rand_field_edge(int k);
        return rand_u128(k);
    endfunction

    // drive inputs, pull from pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (drain_req && pending_q.size() > 0 && quote_q.size() > 0
                         && s_axis_tvalid == 1'b0) begin
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                t_quote q;
                q = pending_q.pop_front();
                quote_q.push_back(quote_result(q));
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= q.func;
                s_axis_tdata  <= {q.amt[127:64], q.amt[63:0], q.d[127:64], q.d[63:0],
                                  q.c[127:64], q.c[63:0], q.b[127:64], q.b[63:0],
                                  q.a[127:64], q.a[63:0]};
                if ($urandom_range(0, 3) == 0) begin
                    src_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                            : $urandom_range(1, 3);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string what, t_u128 got, t_u128 want);
        $display("MISMATCH %s at cycle %0d: got %h want %h", what, cyc, got, want);
        n_err++;
    endtask

    // check results and drive the output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (quote_q.size() == 0) begin
                    report_mismatch("unexpected item", m_axis_tdata, '0);
                end else begin
                    t_u128 want;
                    want = quote_q.pop_front();
                    if (m_axis_tdata[63:0] != want[63:0])
                        report_mismatch("result_lo", m_axis_tdata, want);
                    if (m_axis_tdata[127:64] != want[127:64])
                        report_mismatch("result_hi", m_axis_tdata, want);
                end
            end
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 5) == 0) begin
                    sink_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(1, 3);
                end
            end
        end
    end

    // long output hold, counted in its own process
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (cyc == 3000 || cyc == 40000) begin
            sink_hold <= 1500;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) cyc <= 0;
        else cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_quote(logic f, t_u128 a, t_u128 b, t_u128 c, t_u128 d, t_u128 amt);
        t_quote q;
        q.func = f;
        q.a = a;
        q.b = b;
        q.c = c;
        q.d = d;
        q.amt = amt;
        pending_q.push_back(q);
    endtask

    initial begin
        t_u128 big;
        t_u128 amt;
        n_err         = 0;
        drain_req     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        sink_hold     = 0;
        cyc           = 0;
        big = 128'd1 << 100;
        // zero reserve, zero amount, all-ones extremes
        add_quote(MODE_SWAP, '0, big, '1, '1, 128'd1000);
        add_quote(MODE_SWAP, big, big, '0, '0, '0);
        add_quote(MODE_SWAP, '1, '1, '1, '1, '1);
        add_quote(MODE_SWAP, 128'd1000000, 128'd2000000, '0, '0, 128'd1000);
        add_quote(MODE_SWAP, big, '1, '0, '0, 128'd12345);
        // denominator wraps to zero: a*1000 + amt*997 == 2^128
        add_quote(MODE_SWAP, 128'd0 - 128'd997, 128'd5, '0, '0, 128'd1000);
        // wrapped products, then a balanced round trip
        add_quote(MODE_SWAP, 128'd3, '1, '0, '0, '1 >> 2);
        add_quote(MODE_PROFIT, 128'd1000000, 128'd1000000, 128'd1000000,
                  128'd1000000, 128'd1000);
        // profitable round trips, then zero reserves and all-ones extremes
        add_quote(MODE_PROFIT, 128'd1000000, 128'd4000000, 128'd4000000,
                  128'd1000000, 128'd1000);
        add_quote(MODE_PROFIT, big, big << 2, big << 2, big, 128'd1 << 80);
        add_quote(MODE_PROFIT, '0, big, big, big, 128'd5);
        add_quote(MODE_PROFIT, big, big, big, '0, 128'd5);
        add_quote(MODE_PROFIT, '1, '1, '1, '1, '1);
        add_quote(MODE_PROFIT, big, big, '0, big, big);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 1540; i++) begin
            if (i == 700) begin
                wait (pending_q.size() == 0);
                drain_req = 1'b1;
                wait (quote_q.size() == 0);
                drain_req = 1'b0;
            end
            if ($urandom_range(0, 1) == 0) begin
                add_quote($urandom_range(0, 1), rand_field(), rand_field(), rand_field(),
                          rand_field(), rand_field());
            end else begin
                // realistic pools, sometimes profitable
                big = t_u128'($urandom) << $urandom_range(20, 60);
                amt = big >> $urandom_range(2, 20);
                add_quote($urandom_range(0, 1), big, big * $urandom_range(1, 4),
                          big * $urandom_range(1, 4), big, amt);
            end
        end
        wait (pending_q.size() == 0 && !s_axis_tvalid && quote_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/amm_pkg.sv
hw/rtl/amm_front.sv
hw/rtl/amm_swap.sv
hw/rtl/amm_swap_output_and_round_trip_profit_unit.sv
bench/amm_swap_output_and_round_trip_profit_unit_tb.sv
